// ----- sv/detector_anchor_decode_assert.svh -----
// ----------------------------------------------------------------------------
// detector_anchor_decode_assert.svh
// Assertion macros shared by the detector anchor decode RTL
// ----------------------------------------------------------------------------
`ifndef DETECTOR_ANCHOR_DECODE_ASSERT_SVH
`define DETECTOR_ANCHOR_DECODE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define DAD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define DAD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/dad_pkg.sv -----
// ----------------------------------------------------------------------------
// dad_pkg
// Shared widths, reset values, register indexes and interface structs for
// the detector anchor decode block
// ----------------------------------------------------------------------------
package dad_pkg;

    // field widths
    localparam int FEAT_W     = 16;
    localparam int COORD_W    = 16;
    localparam int SIZE_W     = 15;
    localparam int CLASS_W    = 7;
    localparam int SCORE_W    = 16;
    localparam int ANCHOR_W   = 14;
    localparam int DIM_W      = 13;
    localparam int MASK_LO_W  = 64;
    localparam int MASK_HI_W  = 16;
    localparam int NUM_CLASS  = MASK_LO_W + MASK_HI_W;

    // configuration port
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;

    // stream data widths
    localparam int S_TDATA_W  = 16;
    localparam int M_FIELDS_W = 2 * COORD_W + 2 * SIZE_W + CLASS_W + SCORE_W + ANCHOR_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // scaling unit: signed half-pixel numerator, product magnitude, quotient
    localparam int NUM_W      = FEAT_W + 2;
    localparam int MAG_W      = (NUM_W - 1) + DIM_W;
    localparam int FRAC_SHIFT = 5;
    localparam int QUO_W      = MAG_W - FRAC_SHIFT;
    localparam int QCNT_W     = $clog2(QUO_W);

    // anchor layout
    localparam int BOX_FEATURES = 4;

    // parameter defaults
    localparam int FEATURES_PER_ANCHOR_DEF = 84;
    localparam int MAX_ANCHORS_DEF         = 16384;

    // register reset values
    localparam logic [SCORE_W-1:0]   THRESH_RST  = 16'd32768;
    localparam logic [DIM_W-1:0]     MODEL_RST   = 13'd640;
    localparam logic [DIM_W-1:0]     IMG_W_RST   = 13'd640;
    localparam logic [DIM_W-1:0]     IMG_H_RST   = 13'd480;
    localparam logic [MASK_LO_W-1:0] MASK_LO_RST = 64'h0000_0080_0000_0000;
    localparam logic [MASK_HI_W-1:0] MASK_HI_RST = 16'h0000;
    localparam logic                 FILTER_RST  = 1'b1;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD  = 3'd0,
        REG_MODEL_SIZE = 3'd1,
        REG_IMG_WIDTH  = 3'd2,
        REG_IMG_HEIGHT = 3'd3,
        REG_MASK_LOW   = 3'd4,
        REG_MASK_HIGH  = 3'd5,
        REG_FILTER_EN  = 3'd6
    } cfg_reg_t;

    // request to the scaling unit
    typedef struct packed {
        logic                    start;
        logic signed [NUM_W-1:0] num;
        logic [DIM_W-1:0]        scale;
        logic [DIM_W-1:0]        model;
    } scale_cmd_t;

    // status back from the scaling unit
    typedef struct packed {
        logic               busy;
        logic               done;
        logic [COORD_W-1:0] result;
    } scale_sts_t;

endpackage

// ----- sv/dad_scale.sv -----
// ----------------------------------------------------------------------------
// dad_scale
// Shared scaling unit: trunc(num * scale / (32 * model)) saturated to
// 16 bits signed, a multiply step then one quotient bit per cycle
// ----------------------------------------------------------------------------
module dad_scale (
    input  logic                clk,
    input  logic                rst_n,
    input  dad_pkg::scale_cmd_t cmd,
    output dad_pkg::scale_sts_t sts
);
    import dad_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_DONE
    } state_t;

    state_t             state_reg;
    logic               neg_reg;
    logic [NUM_W-2:0]   mag_reg;
    logic [DIM_W-1:0]   scale_reg;
    logic [DIM_W-1:0]   div_reg;
    logic [QUO_W-1:0]   quo_reg;
    logic [DIM_W-1:0]   rem_reg;
    logic [QCNT_W-1:0]  cnt_reg;
    logic               done_reg;
    logic [COORD_W-1:0] result_reg;

    logic [NUM_W-1:0]   num_abs;
    logic [MAG_W-1:0]   product;
    logic [DIM_W:0]     rem_sh;
    logic [DIM_W+1:0]   diff;
    logic               ge;
    logic [DIM_W-1:0]   rem_next;
    logic [QUO_W-1:0]   quo_next;
    logic               q_over;
    logic [COORD_W-1:0] q_low;
    logic [COORD_W-1:0] sat;

    // magnitude of the numerator, sign kept aside
    assign num_abs = cmd.num[NUM_W-1] ? NUM_W'(-cmd.num) : NUM_W'(cmd.num);

    // product of magnitude and image size
    assign product = MAG_W'(mag_reg) * MAG_W'(scale_reg);

    // one restoring division step
    assign rem_sh   = {rem_reg, quo_reg[QUO_W-1]};
    assign diff     = {1'b0, rem_sh} - {2'b00, div_reg};
    assign ge       = !diff[DIM_W+1];
    assign rem_next = ge ? diff[DIM_W-1:0] : rem_sh[DIM_W-1:0];
    assign quo_next = {quo_reg[QUO_W-2:0], ge};

    // saturate the truncated quotient to 16 bits signed
    assign q_over = |quo_reg[QUO_W-1:COORD_W-1];
    assign q_low  = quo_reg[COORD_W-1:0];
    always_comb
    begin
        if (neg_reg)
        begin
            if (q_over)
                sat = {1'b1, {(COORD_W-1){1'b0}}};
            else
                sat = -q_low;
        end
        else
        begin
            if (q_over)
                sat = {1'b0, {(COORD_W-1){1'b1}}};
            else
                sat = q_low;
        end
    end

    // sequencer and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            neg_reg    <= 1'b0;
            mag_reg    <= '0;
            scale_reg  <= '0;
            div_reg    <= '0;
            quo_reg    <= '0;
            rem_reg    <= '0;
            cnt_reg    <= '0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd.start)
                    begin
                        neg_reg   <= cmd.num[NUM_W-1];
                        mag_reg   <= num_abs[NUM_W-2:0];
                        scale_reg <= cmd.scale;
                        div_reg   <= cmd.model;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    // drop the factor 32 before dividing by the model size
                    quo_reg   <= product[MAG_W-1:FRAC_SHIFT];
                    rem_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    quo_reg <= quo_next;
                    rem_reg <= rem_next;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == QCNT_W'(QUO_W - 1))
                        state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    result_reg <= sat;
                    done_reg   <= 1'b1;
                    state_reg  <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign sts.busy   = (state_reg != S_IDLE);
    assign sts.done   = done_reg;
    assign sts.result = result_reg;

endmodule

// ----- sv/detector_anchor_decode.sv -----
// ----------------------------------------------------------------------------
// detector_anchor_decode
// Decodes detector output features into thresholded, filtered detections
// with boxes scaled from model size to image size
// ----------------------------------------------------------------------------
// channel     dir  beat contents
// s_axis      in   tdata[15:0] feature_value, tlast last_of_anchor,
//                  tuser last_of_frame
// m_axis      out  tdata box_x, box_y, box_w, box_h, class_num, confidence,
//                  anchor_index (low bits first, zero padded to 104 bits)
// cfg         in   cfg_we, cfg_index, cfg_data; writes take effect at once
//
// feature beats are accepted whenever the block is idle; the last beat of an
// anchor that yields a detection holds the input while the shared scaling
// unit runs four times (start, multiply, 25 restoring quotient steps,
// saturate, hand back), then the hold state loads the output register;
// input resumes while that beat waits for m_axis_tready; a second detection
// waits in the hold state until the first leaves; rst_n resets all state
// ----------------------------------------------------------------------------
`include "detector_anchor_decode_assert.svh"

module detector_anchor_decode #(
    parameter int FEATURES_PER_ANCHOR = dad_pkg::FEATURES_PER_ANCHOR_DEF,
    parameter int MAX_ANCHORS         = dad_pkg::MAX_ANCHORS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write port
    input  logic                           cfg_we,
    input  logic [dad_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dad_pkg::CFG_DATA_W-1:0] cfg_data,
    // feature input
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [dad_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // feature_value
    input  logic                           s_axis_tlast,  // last_of_anchor
    input  logic                           s_axis_tuser,  // last_of_frame
    // detection output
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // box_x, box_y, box_w, box_h, class_num, confidence, anchor_index, pad
    output logic [dad_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
    import dad_pkg::*;

    localparam int FCW = $clog2(FEATURES_PER_ANCHOR);
    localparam int ACW = $clog2(MAX_ANCHORS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT,
        ST_HOLD
    } state_t;

    typedef enum logic [1:0] {
        OP_X,
        OP_Y,
        OP_W,
        OP_H
    } op_t;

    // configuration registers
    logic [SCORE_W-1:0]   thresh_reg;
    logic [DIM_W-1:0]     model_reg;
    logic [DIM_W-1:0]     img_w_reg;
    logic [DIM_W-1:0]     img_h_reg;
    logic [MASK_LO_W-1:0] mask_lo_reg;
    logic [MASK_HI_W-1:0] mask_hi_reg;
    logic                 filter_reg;

    // anchor state
    state_t               state_reg;
    op_t                  op_reg;
    logic [FCW-1:0]       feat_cnt_reg;
    logic [FEAT_W-1:0]    cx_reg;
    logic [FEAT_W-1:0]    cy_reg;
    logic [FEAT_W-1:0]    rw_reg;
    logic [FEAT_W-1:0]    rh_reg;
    logic [SCORE_W-1:0]   best_score_reg;
    logic [CLASS_W-1:0]   best_class_reg;
    logic                 found_reg;
    logic [ACW-1:0]       anchor_cnt_reg;

    // pending detection
    logic [CLASS_W-1:0]   pend_class_reg;
    logic [SCORE_W-1:0]   pend_score_reg;
    logic [ACW-1:0]       pend_anchor_reg;
    logic [COORD_W-1:0]   box_x_reg;
    logic [COORD_W-1:0]   box_y_reg;
    logic [SIZE_W-1:0]    box_w_reg;
    logic [SIZE_W-1:0]    box_h_reg;
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    logic                 accept;
    logic [FEAT_W-1:0]    feat;
    logic                 is_score;
    logic                 upd;
    logic [SCORE_W-1:0]   score_next;
    logic [CLASS_W-1:0]   class_next;
    logic                 found_next;
    logic                 anchor_end;
    logic [NUM_CLASS-1:0] mask_all;
    logic                 passes;
    logic                 emit;
    logic                 out_free;
    logic [DIM_W-1:0]     model_eff;
    logic [M_TDATA_W-1:0] pack;
    scale_cmd_t           scl_cmd;
    scale_sts_t           scl_sts;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg  <= THRESH_RST;
            model_reg   <= MODEL_RST;
            img_w_reg   <= IMG_W_RST;
            img_h_reg   <= IMG_H_RST;
            mask_lo_reg <= MASK_LO_RST;
            mask_hi_reg <= MASK_HI_RST;
            filter_reg  <= FILTER_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_THRESHOLD:  thresh_reg  <= cfg_data[SCORE_W-1:0];
                REG_MODEL_SIZE: model_reg   <= cfg_data[DIM_W-1:0];
                REG_IMG_WIDTH:  img_w_reg   <= cfg_data[DIM_W-1:0];
                REG_IMG_HEIGHT: img_h_reg   <= cfg_data[DIM_W-1:0];
                REG_MASK_LOW:   mask_lo_reg <= cfg_data[MASK_LO_W-1:0];
                REG_MASK_HIGH:  mask_hi_reg <= cfg_data[MASK_HI_W-1:0];
                REG_FILTER_EN:  filter_reg  <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // input handshake
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign feat          = s_axis_tdata[FEAT_W-1:0];

    // running argmax, strict greater so the first of equal scores wins
    assign is_score   = (feat_cnt_reg >= FCW'(BOX_FEATURES));
    assign upd        = is_score && (feat > best_score_reg);
    assign score_next = upd ? feat : best_score_reg;
    assign class_next = upd ? CLASS_W'(feat_cnt_reg - FCW'(BOX_FEATURES)) : best_class_reg;
    assign found_next = upd || found_reg;

    assign anchor_end = s_axis_tlast || s_axis_tuser
                     || (feat_cnt_reg == FCW'(FEATURES_PER_ANCHOR - 1));

    // class filter; classes past the mask fail when it applies
    assign mask_all = {mask_hi_reg, mask_lo_reg};
    assign passes   = !filter_reg
                   || ((mask_lo_reg == '0) && (mask_hi_reg == '0))
                   || ((class_next < CLASS_W'(NUM_CLASS)) && mask_all[class_next]);
    assign emit     = found_next && (score_next > thresh_reg) && passes;

    // request to the scaling unit, one box term per op
    assign model_eff = (model_reg == '0) ? DIM_W'(1) : model_reg;
    always_comb
    begin
        scl_cmd.start = (state_reg == ST_START);
        scl_cmd.model = model_eff;
        unique case (op_reg)
            OP_X:
            begin
                scl_cmd.num   = $signed({1'b0, cx_reg, 1'b0}) - $signed({2'b00, rw_reg});
                scl_cmd.scale = img_w_reg;
            end
            OP_Y:
            begin
                scl_cmd.num   = $signed({1'b0, cy_reg, 1'b0}) - $signed({2'b00, rh_reg});
                scl_cmd.scale = img_h_reg;
            end
            OP_W:
            begin
                scl_cmd.num   = $signed({1'b0, rw_reg, 1'b0});
                scl_cmd.scale = img_w_reg;
            end
            OP_H:
            begin
                scl_cmd.num   = $signed({1'b0, rh_reg, 1'b0});
                scl_cmd.scale = img_h_reg;
            end
            default:
            begin
                scl_cmd.num   = '0;
                scl_cmd.scale = '0;
            end
        endcase
    end

    dad_scale u_scale (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (scl_cmd),
        .sts   (scl_sts)
    );

    // output beat layout
    assign pack = {{(M_TDATA_W - M_FIELDS_W){1'b0}},
                   ANCHOR_W'(pend_anchor_reg), pend_score_reg, pend_class_reg,
                   box_h_reg, box_w_reg, box_y_reg, box_x_reg};
    assign out_free = !m_valid_reg || m_axis_tready;

    // sequencer, anchor state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            op_reg          <= OP_X;
            feat_cnt_reg    <= '0;
            cx_reg          <= '0;
            cy_reg          <= '0;
            rw_reg          <= '0;
            rh_reg          <= '0;
            best_score_reg  <= '0;
            best_class_reg  <= '0;
            found_reg       <= 1'b0;
            anchor_cnt_reg  <= '0;
            pend_class_reg  <= '0;
            pend_score_reg  <= '0;
            pend_anchor_reg <= '0;
            box_x_reg       <= '0;
            box_y_reg       <= '0;
            box_w_reg       <= '0;
            box_h_reg       <= '0;
            m_valid_reg     <= 1'b0;
            m_data_reg      <= '0;
        end
        else
        begin
            // the hold state reloads the register itself when it frees up
            if (m_valid_reg && m_axis_tready && (state_reg != ST_HOLD))
                m_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        // box features land in their own registers
                        if (feat_cnt_reg == FCW'(0))
                            cx_reg <= feat;
                        if (feat_cnt_reg == FCW'(1))
                            cy_reg <= feat;
                        if (feat_cnt_reg == FCW'(2))
                            rw_reg <= feat;
                        if (feat_cnt_reg == FCW'(3))
                            rh_reg <= feat;

                        if (!anchor_end)
                        begin
                            feat_cnt_reg   <= feat_cnt_reg + 1'b1;
                            best_score_reg <= score_next;
                            best_class_reg <= class_next;
                            found_reg      <= found_next;
                        end
                        else
                        begin
                            feat_cnt_reg   <= '0;
                            best_score_reg <= '0;
                            best_class_reg <= '0;
                            found_reg      <= 1'b0;
                            if (s_axis_tuser || (anchor_cnt_reg == ACW'(MAX_ANCHORS - 1)))
                                anchor_cnt_reg <= '0;
                            else
                                anchor_cnt_reg <= anchor_cnt_reg + 1'b1;
                            if (emit)
                            begin
                                pend_class_reg  <= class_next;
                                pend_score_reg  <= score_next;
                                pend_anchor_reg <= anchor_cnt_reg;
                                op_reg          <= OP_X;
                                state_reg       <= ST_START;
                            end
                        end
                    end
                end
                ST_START:
                begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT:
                begin
                    if (scl_sts.done)
                    begin
                        unique case (op_reg)
                            OP_X: box_x_reg <= scl_sts.result;
                            OP_Y: box_y_reg <= scl_sts.result;
                            OP_W: box_w_reg <= scl_sts.result[SIZE_W-1:0];
                            OP_H: box_h_reg <= scl_sts.result[SIZE_W-1:0];
                            default: ;
                        endcase
                        if (op_reg == OP_H)
                        begin
                            state_reg <= ST_HOLD;
                        end
                        else
                        begin
                            op_reg    <= op_t'(op_reg + 1'b1);
                            state_reg <= ST_START;
                        end
                    end
                end
                ST_HOLD:
                begin
                    if (out_free)
                    begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= pack;
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // checks on the sequencer and the scaling unit
    `DAD_ASSERT_IMP(a_no_accept_busy, accept, !scl_sts.busy, "input taken while scaling")
    `DAD_ASSERT_IMP(a_done_in_wait, scl_sts.done, state_reg == ST_WAIT, "scale result unexpected")
    `DAD_ASSERT_NXT(a_start_runs, state_reg == ST_START, scl_sts.busy, "scale unit did not start")
    `DAD_ASSERT_IMP(a_out_from_hold, $rose(m_valid_reg), $past(state_reg == ST_HOLD), "stray output")

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for detector_anchor_decode. Feature beats go in on the
// input stream while a tracker class mirrors the anchor decoding (box
// capture, running argmax, threshold, class filter, scaling, saturation) and
// queues the detection each anchor should yield. Every detection beat on the
// output stream is compared field by field against the oldest queued one.
// The run covers directed corner anchors and several register settings,
// with random stalls on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import dad_pkg::*;

    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int SETTLE_CYCLES  = 200;
    localparam int HOLD_CYCLES    = 2500;
    localparam int NUM_PHASES     = 8;
    localparam int DIRECTED_PHASE = 8;

    // one detection, packed in output stream order (box_x in the low bits)
    typedef struct packed {
        logic [ANCHOR_W-1:0] anchor_idx;
        logic [SCORE_W-1:0]  conf;
        logic [CLASS_W-1:0]  cls;
        logic [SIZE_W-1:0]   h;
        logic [SIZE_W-1:0]   w;
        logic [COORD_W-1:0]  y;
        logic [COORD_W-1:0]  x;
    } detection_t;

    // register setting and stimulus shape of one phase
    typedef struct {
        logic [SCORE_W-1:0]   thr;
        logic [DIM_W-1:0]     model;
        logic [DIM_W-1:0]     iw;
        logic [DIM_W-1:0]     ih;
        logic [MASK_LO_W-1:0] mlo;
        logic [MASK_HI_W-1:0] mhi;
        logic                 fen;
        int                   min_s;
        int                   max_s;
        int                   items;
    } phase_t;

    // mirrors the decoder and holds the detections still due
    class detection_tracker;
        logic [SCORE_W-1:0]   thresh;
        logic [DIM_W-1:0]     model_side;
        logic [DIM_W-1:0]     img_w;
        logic [DIM_W-1:0]     img_h;
        logic [MASK_LO_W-1:0] mask_lo;
        logic [MASK_HI_W-1:0] mask_hi;
        logic                 filt_en;

        logic [6:0]           feat_pos;
        logic [FEAT_W-1:0]    cx;
        logic [FEAT_W-1:0]    cy;
        logic [FEAT_W-1:0]    bw;
        logic [FEAT_W-1:0]    bh;
        logic [SCORE_W-1:0]   top_score;
        logic [CLASS_W-1:0]   top_class;
        bit                   have_class;
        logic [ANCHOR_W-1:0]  anchor_num;

        detection_t           due[$];
        int                   errors;

        function new();
            thresh     = 16'd32768;
            model_side = 13'd640;
            img_w      = 13'd640;
            img_h      = 13'd480;
            mask_lo    = 64'd1 << 39;
            mask_hi    = '0;
            filt_en    = 1'b1;
            feat_pos   = '0;
            cx         = '0;
            cy         = '0;
            bw         = '0;
            bh         = '0;
            top_score  = '0;
            top_class  = '0;
            have_class = 1'b0;
            anchor_num = '0;
            errors     = 0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_THRESHOLD:  thresh     = val[SCORE_W-1:0];
                REG_MODEL_SIZE: model_side = val[DIM_W-1:0];
                REG_IMG_WIDTH:  img_w      = val[DIM_W-1:0];
                REG_IMG_HEIGHT: img_h      = val[DIM_W-1:0];
                REG_MASK_LOW:   mask_lo    = val;
                REG_MASK_HIGH:  mask_hi    = val[MASK_HI_W-1:0];
                REG_FILTER_EN:  filt_en    = val[0];
                default: ;
            endcase
        endfunction

        // classes past the high mask have no bit and fail an active filter
        function bit class_ok(int cls);
            if (!filt_en)
                return 1'b1;
            if (mask_lo == 0 && mask_hi == 0)
                return 1'b1;
            if (cls < MASK_LO_W)
                return mask_lo[cls];
            if (cls < NUM_CLASS)
                return mask_hi[cls-MASK_LO_W];
            return 1'b0;
        endfunction

        // numerator in half pixels, so the divisor carries a factor of 32
        function longint scaled(longint num_half, logic [DIM_W-1:0] s);
            longint div;
            div = (model_side == 0) ? 64'sd32 : longint'(model_side) * 32;
            return (num_half * longint'(s)) / div;
        endfunction

        function logic [COORD_W-1:0] sat_s16(longint v);
            if (v > 32767)
                return 16'h7FFF;
            if (v < -32768)
                return 16'h8000;
            return 16'(v);
        endfunction

        function logic [SIZE_W-1:0] sat_u15(longint v);
            if (v > 32767)
                return 15'h7FFF;
            if (v < 0)
                return '0;
            return 15'(v);
        endfunction

        // one accepted feature beat
        function void take_feature(logic [FEAT_W-1:0] v, bit la, bit lf);
            logic [6:0] pos;
            detection_t d;
            longint     xh;
            longint     yh;
            pos = feat_pos;
            if (pos == 0)
                cx = v;
            else if (pos == 1)
                cy = v;
            else if (pos == 2)
                bw = v;
            else if (pos == 3)
                bh = v;
            else if (v > top_score)
            begin
                top_score  = v;
                top_class  = CLASS_W'(pos - BOX_FEATURES);
                have_class = 1'b1;
            end

            if (!la && !lf && pos < FEATURES_PER_ANCHOR_DEF - 1)
            begin
                feat_pos = pos + 7'd1;
                return;
            end

            // anchor closes here
            if (have_class && top_score > thresh && class_ok(top_class))
            begin
                xh           = 2 * longint'(cx) - longint'(bw);
                yh           = 2 * longint'(cy) - longint'(bh);
                d.x          = sat_s16(scaled(xh, img_w));
                d.y          = sat_s16(scaled(yh, img_h));
                d.w          = sat_u15(scaled(2 * longint'(bw), img_w));
                d.h          = sat_u15(scaled(2 * longint'(bh), img_h));
                d.cls        = top_class;
                d.conf       = top_score;
                d.anchor_idx = anchor_num;
                due = {due, d};
            end
            anchor_num = lf ? '0 : anchor_num + 1'b1;
            feat_pos   = '0;
            top_score  = '0;
            top_class  = '0;
            have_class = 1'b0;
        endfunction

        task report(string what, longint got_v, longint want_v);
            errors++;
            if (errors <= 40)
                $display("[%0t] %s: got %0d, expected %0d", $time, what, got_v, want_v);
        endtask

        // one accepted detection beat
        task check_detection(logic [M_TDATA_W-1:0] beat);
            detection_t got;
            detection_t want;
            got = beat[$bits(detection_t)-1:0];
            if (due.size() == 0)
            begin
                report("detection with none pending, anchor", got.anchor_idx, -1);
                return;
            end
            want = due.pop_front();
            if (got.x !== want.x)
                report("box_x", $signed(got.x), $signed(want.x));
            if (got.y !== want.y)
                report("box_y", $signed(got.y), $signed(want.y));
            if (got.w !== want.w)
                report("box_w", got.w, want.w);
            if (got.h !== want.h)
                report("box_h", got.h, want.h);
            if (got.cls !== want.cls)
                report("class_num", got.cls, want.cls);
            if (got.conf !== want.conf)
                report("confidence", got.conf, want.conf);
            if (got.anchor_idx !== want.anchor_idx)
                report("anchor_index", got.anchor_idx, want.anchor_idx);
        endtask
    endclass

    logic                  clk;
    logic                  rst_n         = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tlast  = 1'b0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;

    detection_tracker tracker = new();

    int send_idle   = 0;
    int recv_idle   = 0;
    int recv_hold   = 0;
    int beats_sent  = 0;
    int cycle_count = 0;

    detector_anchor_decode u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // feature_value
        .s_axis_tlast  (s_axis_tlast),   // last_of_anchor
        .s_axis_tuser  (s_axis_tuser),   // last_of_frame
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // box_x, box_y, box_w, box_h, class_num,
                                         // confidence, anchor_index, pad
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // detection sink: check accepted beats, stall at random or on hold-off
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                tracker.check_detection(m_axis_tdata);
            if (recv_hold > 0)
            begin
                recv_hold--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    task automatic send_beat(input logic [FEAT_W-1:0] v, input bit la, input bit lf);
        while ($urandom_range(0, 99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tlast  <= la;
        s_axis_tuser  <= lf;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        tracker.take_feature(v, la, lf);
        beats_sent++;
    endtask

    task automatic send_box(input logic [FEAT_W-1:0] bx, input logic [FEAT_W-1:0] by,
                            input logic [FEAT_W-1:0] bwid, input logic [FEAT_W-1:0] bht);
        send_beat(bx, 1'b0, 1'b0);
        send_beat(by, 1'b0, 1'b0);
        send_beat(bwid, 1'b0, 1'b0);
        send_beat(bht, 1'b0, 1'b0);
    endtask

    function automatic logic [FEAT_W-1:0] pick_box();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return FEAT_W'($urandom);
        endcase
    endfunction

    // scores lean toward zero and the threshold edge
    function automatic logic [SCORE_W-1:0] pick_score();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return tracker.thresh;
            2:       return tracker.thresh + 1'b1;
            default: return SCORE_W'($urandom);
        endcase
    endfunction

    // one anchor: mostly well formed, some short ones and some noise
    task automatic send_random_anchor(input int min_s, input int max_s);
        int kind;
        int n_box;
        int n_sc;
        int hot;
        int endk;
        int len;
        bit la_end;
        bit lf_end;
        bit at_end;
        int ok_list[$];
        kind = $urandom_range(0, 99);
        if (kind < 8)
        begin
            // box features only, closed early
            n_box = $urandom_range(1, 4);
            for (int i = 0; i < n_box; i++)
                send_beat(pick_box(), i == n_box - 1, (i == n_box - 1) && ($urandom_range(0, 3) == 0));
        end
        else if (kind < 15)
        begin
            // noise with stray markers
            len = $urandom_range(1, 20);
            for (int i = 0; i < len; i++)
                send_beat(FEAT_W'($urandom), $urandom_range(0, 7) == 0, $urandom_range(0, 15) == 0);
        end
        else
        begin
            n_sc = $urandom_range(min_s, max_s);
            hot  = -1;
            for (int c = 0; c < n_sc; c++)
                if (tracker.class_ok(c))
                    ok_list = {ok_list, c};
            if (ok_list.size() != 0 && $urandom_range(0, 3) != 0)
                hot = ok_list[$urandom_range(0, ok_list.size() - 1)];
            endk   = $urandom_range(0, 9);
            la_end = (endk < 9);
            lf_end = (endk >= 7);
            // a full anchor may also close on its feature count alone
            if (n_sc == FEATURES_PER_ANCHOR_DEF - BOX_FEATURES && $urandom_range(0, 2) == 0)
            begin
                la_end = 1'b0;
                lf_end = 1'b0;
            end
            send_box(pick_box(), pick_box(), pick_box(), pick_box());
            for (int i = 0; i < n_sc; i++)
            begin
                at_end = (i == n_sc - 1);
                send_beat((i == hot) ? 16'hFFFF - 16'($urandom_range(0, 3)) : pick_score(),
                          at_end && la_end, at_end && lf_end);
            end
        end
    endtask

    // stop the stream and let the block finish all pending work
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (tracker.due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        tracker.write_reg(idx, val);
    endtask

    task automatic load_config(input phase_t c);
        cfg_write(REG_THRESHOLD, 64'(c.thr));
        cfg_write(REG_MODEL_SIZE, 64'(c.model));
        cfg_write(REG_IMG_WIDTH, 64'(c.iw));
        cfg_write(REG_IMG_HEIGHT, 64'(c.ih));
        cfg_write(REG_MASK_LOW, c.mlo);
        cfg_write(REG_MASK_HIGH, 64'(c.mhi));
        cfg_write(REG_FILTER_EN, 64'(c.fen));
        cfg_we <= 1'b0;
    endtask

    function automatic phase_t plan_phase(int p);
        phase_t c;
        c.thr   = SCORE_W'($urandom);
        c.model = DIM_W'($urandom_range(32, 4096));
        c.iw    = DIM_W'($urandom_range(1, 4096));
        c.ih    = DIM_W'($urandom_range(1, 4096));
        c.mlo   = {$urandom, $urandom};
        c.mhi   = MASK_HI_W'($urandom);
        c.fen   = 1'b1;
        c.min_s = 1;
        c.max_s = 12;
        c.items = 250;
        case (p)
            // power-on values
            0:
            begin
                c.thr   = 16'd32768;
                c.model = 13'd640;
                c.iw    = 13'd640;
                c.ih    = 13'd480;
                c.mlo   = 64'd1 << 39;
                c.mhi   = '0;
                c.min_s = 40;
                c.max_s = FEATURES_PER_ANCHOR_DEF - BOX_FEATURES;
                c.items = 300;
            end
            // everything passes, largest sizes
            1:
            begin
                c.thr   = '0;
                c.model = 13'd4096;
                c.iw    = 13'd4096;
                c.ih    = 13'd4096;
                c.mlo   = '1;
                c.mhi   = '1;
            end
            // top threshold, nothing can pass
            2:
            begin
                c.thr   = 16'hFFFF;
                c.model = 13'd1000;
                c.iw    = 13'd1;
                c.ih    = 13'd1;
                c.max_s = 20;
                c.items = 120;
            end
            // filter off with a random mask
            3:
                c.fen = 1'b0;
            // empty mask, zero model and zero width
            4:
            begin
                c.thr   = SCORE_W'($urandom_range(0, 32768));
                c.model = '0;
                c.iw    = '0;
                c.mlo   = '0;
                c.mhi   = '0;
            end
            // only the high classes enabled
            5:
            begin
                c.mlo   = '0;
                c.mhi   = MASK_HI_W'($urandom_range(1, 16'hFFFF));
                c.min_s = 60;
                c.max_s = FEATURES_PER_ANCHOR_DEF - BOX_FEATURES;
                c.items = 300;
            end
            // smallest model, saturating boxes, detections on nearly every anchor
            6:
            begin
                c.thr   = '0;
                c.model = 13'd32;
                c.iw    = 13'd4096;
                c.ih    = 13'd4096;
                c.fen   = 1'b0;
                c.max_s = 8;
            end
            7:
            begin
                c.thr   = SCORE_W'($urandom_range(0, 16'hFFFE));
                c.mlo   = c.mlo | 64'd1;
                c.items = 230;
            end
            DIRECTED_PHASE:
            begin
                c.thr   = 16'h0100;
                c.model = 13'd32;
                c.iw    = 13'd4096;
                c.ih    = 13'd1;
                c.mlo   = 64'd1;
                c.mhi   = 16'h8000;
            end
            default: ;
        endcase
        return c;
    endfunction

    // main sequence
    initial
    begin
        phase_t plan;
        int     target;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners
        send_idle = 32;
        recv_idle = 46;
        load_config(plan_phase(DIRECTED_PHASE));
        // one-beat anchor
        send_beat(16'h1234, 1'b1, 1'b0);
        // negative edges, saturated width
        send_box(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
        send_beat(16'hFFFF, 1'b1, 1'b0);
        // tied scores, first wins; frame closed by tuser alone
        send_box(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
        send_beat(16'h0200, 1'b0, 1'b0);
        send_beat(16'h0200, 1'b0, 1'b1);
        // no positive score
        send_box(pick_box(), pick_box(), pick_box(), pick_box());
        send_beat(16'h0000, 1'b1, 1'b0);
        // score equal to threshold
        send_box(pick_box(), pick_box(), pick_box(), pick_box());
        send_beat(16'h0100, 1'b1, 1'b1);
        // best class masked out
        send_box(pick_box(), pick_box(), pick_box(), pick_box());
        send_beat(16'h0050, 1'b0, 1'b0);
        send_beat(16'hFFFF, 1'b1, 1'b0);
        // anchor closed inside the box
        send_beat(16'h8000, 1'b0, 1'b0);
        send_beat(16'h7FFF, 1'b0, 1'b0);
        send_beat(16'h5555, 1'b1, 1'b0);

        // random phases
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            plan = plan_phase(p);
            drain();
            if (p < 3)
            begin
                send_idle = 32;
                recv_idle = 46;
            end
            else if (p < 6)
            begin
                send_idle = 46;
                recv_idle = 32;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            load_config(plan);
            if (p == 6)
                recv_hold = HOLD_CYCLES;
            target = beats_sent + plan.items;
            while (beats_sent < target)
                send_random_anchor(plan.min_s, plan.max_s);
        end

        // a few closing anchors with sure detections
        repeat (3)
        begin
            send_box(pick_box(), pick_box(), pick_box(), pick_box());
            send_beat(16'hFFFF, 1'b1, 1'b0);
        end

        drain();
        if (tracker.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/dad_pkg.sv
sv/dad_scale.sv
sv/detector_anchor_decode.sv
tb/tb_top.sv
